>>> sv/log_frame_crc32c_validator_unit_macros.svh
// assertion macros shared by the validator checker
`ifndef LOG_FRAME_CRC32C_VALIDATOR_UNIT_MACROS_SVH
`define LOG_FRAME_CRC32C_VALIDATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define LFCV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("log frame validator check failed");

// next-cycle implication, sampled on clk, quiet during rst
`define LFCV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("log frame validator check failed");

`endif

>>> sv/lfcv_pkg.sv
// shared types and constants of the log frame crc32c validator
`default_nettype none

package lfcv_pkg;

  // crc32c, reflected castagnoli
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // header layout
  localparam logic [4:0] HDR_CRC_SPAN = 5'd9;
  localparam logic [4:0] HDR_LAST     = 5'd16;
  localparam logic [4:0] HDR_LEN_LAST = 5'd4;
  localparam logic [4:0] HDR_TS_LAST  = 5'd8;
  localparam logic [4:0] HDR_HC_LAST  = 5'd12;
  localparam logic [7:0] KIND_MAX     = 8'd2;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_TS_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd1;
  localparam logic [1:0] CFG_COMPACT     = 2'd2;
  localparam logic [31:0] TS_LIMIT_RST    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd16777216;
  localparam logic [1:0]  COMPACT_RST     = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HDR_CRC   = 3'd1,
    ST_KIND      = 3'd2,
    ST_FIELDS    = 3'd3,
    ST_FRAME_CRC = 3'd4,
    ST_TRUNC     = 3'd5
  } status_t;

  // parser phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_SKIP    = 4'b1000
  } phase_t;

  // one input word as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       end_of_buffer;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [31:0] frame_checksum;
    logic [31:0] stamp;
    logic [31:0] payload_bytes;
    logic [7:0]  record_kind;
    status_t     status;
  } result_t;

  localparam int OUT_BITS  = $bits(result_t);
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_PAD   = OUT_BYTES * 8 - OUT_BITS;

endpackage

`default_nettype wire

>>> sv/lfcv_crc_byte.sv
// one-byte crc32c update, reflected, eight bit steps
`default_nettype none

module lfcv_crc_byte
  import lfcv_pkg::*;
(
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [31:0] crc_out
);

  // fold the byte in, then shift out eight bits
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

>>> sv/lfcv_frame_ctrl.sv
// frame parser, header checks, config registers and result register
`default_nettype none

module lfcv_frame_ctrl
  import lfcv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        word_valid,
  input  wire in_word_t    word,
  output logic             advance,
  output logic             res_valid,
  output result_t          res,
  input  wire logic        res_ready
);

  logic [31:0] ts_limit;
  logic [31:0] max_payload;
  logic [1:0]  compact_kind;

  phase_t      phase, phase_next;
  logic [4:0]  header_position, header_position_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic [31:0] running_crc, running_crc_next;
  logic [7:0]  kind_reg, kind_next;
  logic [31:0] length_reg, length_next;
  logic [31:0] stamp_reg, stamp_next;
  logic [31:0] header_crc_reg, header_crc_next;
  logic [31:0] frame_crc_reg, frame_crc_next;

  logic        proc;
  logic        emit;
  status_t     emit_status;
  logic [31:0] crc_seed;
  logic [31:0] crc_upd;

  // result register frees when empty or being taken
  assign advance = !res_valid || res_ready;
  assign proc    = word_valid && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ts_limit     <= TS_LIMIT_RST;
      max_payload  <= MAX_PAYLOAD_RST;
      compact_kind <= COMPACT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TS_LIMIT:    ts_limit     <= cfg_data;
        CFG_MAX_PAYLOAD: max_payload  <= cfg_data;
        CFG_COMPACT:     compact_kind <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // crc restarts from all ones on a frame start
  assign crc_seed = word.frame_start ? CRC_INIT : running_crc;

  lfcv_crc_byte u_crc (
    .crc_in  (crc_seed),
    .data_in (word.data_byte),
    .crc_out (crc_upd)
  );

  // next state and result for the word in the input register
  always_comb begin
    logic [4:0] pos;
    logic [1:0] lane;
    logic       ok_fields;
    phase_next             = phase;
    header_position_next   = header_position;
    payload_remaining_next = payload_remaining;
    running_crc_next       = running_crc;
    kind_next              = kind_reg;
    length_next            = length_reg;
    stamp_next             = stamp_reg;
    header_crc_next        = header_crc_reg;
    frame_crc_next         = frame_crc_reg;
    emit                   = 1'b0;
    emit_status            = ST_OK;
    pos                    = header_position;
    lane                   = 2'd0;
    ok_fields              = 1'b0;

    if (proc) begin
      // frame start drops whatever was in flight
      if (word.frame_start) begin
        phase_next             = PH_HEADER;
        header_position_next   = 5'd0;
        payload_remaining_next = 32'd0;
        running_crc_next       = CRC_INIT;
        kind_next              = 8'd0;
        length_next            = 32'd0;
        stamp_next             = 32'd0;
        header_crc_next        = 32'd0;
        frame_crc_next         = 32'd0;
        pos                    = 5'd0;
      end

      if (phase_next == PH_HEADER) begin
        if (pos < HDR_CRC_SPAN) begin
          running_crc_next = crc_upd;
        end
        // every 4-byte field starts one past a multiple of four
        lane = pos[1:0] - 2'd1;
        if (pos == 5'd0) begin
          kind_next = word.data_byte;
        end else if (pos <= HDR_LEN_LAST) begin
          length_next[{lane, 3'b000} +: 8] = word.data_byte;
        end else if (pos <= HDR_TS_LAST) begin
          stamp_next[{lane, 3'b000} +: 8] = word.data_byte;
        end else if (pos <= HDR_HC_LAST) begin
          header_crc_next[{lane, 3'b000} +: 8] = word.data_byte;
        end else if (pos <= HDR_LAST) begin
          frame_crc_next[{lane, 3'b000} +: 8] = word.data_byte;
        end

        if (pos < HDR_LAST) begin
          header_position_next = pos + 5'd1;
          if (word.end_of_buffer) begin
            emit        = 1'b1;
            emit_status = ST_TRUNC;
          end
        end else begin
          ok_fields = (stamp_next != 32'd0) && (stamp_next < ts_limit) &&
                      (length_next <= max_payload) &&
                      ((kind_next == {6'd0, compact_kind}) == (length_next == 32'd0));
          emit = 1'b1;
          if (header_crc_next != ~running_crc_next) begin
            emit_status = ST_HDR_CRC;
          end else if (kind_next > KIND_MAX) begin
            emit_status = ST_KIND;
          end else if (!ok_fields) begin
            emit_status = ST_FIELDS;
          end else if (length_next == 32'd0) begin
            emit_status = (frame_crc_next == ~running_crc_next) ? ST_OK : ST_FRAME_CRC;
          end else begin
            payload_remaining_next = length_next;
            phase_next             = PH_PAYLOAD;
            emit                   = word.end_of_buffer;
            emit_status            = ST_TRUNC;
          end
        end
      end else if (phase_next == PH_PAYLOAD) begin
        running_crc_next       = crc_upd;
        payload_remaining_next = payload_remaining - 32'd1;
        if (payload_remaining_next == 32'd0) begin
          emit        = 1'b1;
          emit_status = (frame_crc_reg == ~crc_upd) ? ST_OK : ST_FRAME_CRC;
        end else if (word.end_of_buffer) begin
          emit        = 1'b1;
          emit_status = ST_TRUNC;
        end
      end

      // after a result, wait for the next frame start
      if (emit) begin
        phase_next = (emit_status == ST_OK) ? PH_IDLE : PH_SKIP;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      header_position   <= 5'd0;
      payload_remaining <= 32'd0;
      running_crc       <= CRC_INIT;
      kind_reg          <= 8'd0;
      length_reg        <= 32'd0;
      stamp_reg         <= 32'd0;
      header_crc_reg    <= 32'd0;
      frame_crc_reg     <= 32'd0;
    end else begin
      phase             <= phase_next;
      header_position   <= header_position_next;
      payload_remaining <= payload_remaining_next;
      running_crc       <= running_crc_next;
      kind_reg          <= kind_next;
      length_reg        <= length_next;
      stamp_reg         <= stamp_next;
      header_crc_reg    <= header_crc_next;
      frame_crc_reg     <= frame_crc_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res.status         <= emit_status;
      res.record_kind    <= kind_next;
      res.payload_bytes  <= length_next;
      res.stamp          <= stamp_next;
      res.frame_checksum <= frame_crc_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/log_frame_crc32c_validator_unit.sv
// Log frame CRC32C validator, top level.
// Input stream: one frame byte per word on s_tdata, s_tuser marks the first
// header byte of a frame, s_tlast marks the last byte of the buffer.
// Output stream: at most one status word per frame on m_tdata (status, kind,
// length, timestamp and frame crc field from the header).
// Configuration: cfg_we with cfg_index 0 timestamp limit, 1 max payload
// length, 2 compact kind code; write only while no frame is in flight.
// Path: a byte taken into the input register passes through the parser into
// the result register, which presents the result word.
// Throughput: one byte per cycle while the result register is empty or taken;
// the byte-wide crc32c update and the header compares sit between the input
// register and the result register.
// When m_tready is low the result register holds its word and s_tready drops
// once the input register is also full; nothing is lost or repeated.
// Reset (rst, synchronous) empties both registers, sets the parser idle and
// restores the configuration defaults.
`default_nettype none

module log_frame_crc32c_validator_unit
  import lfcv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // data_byte
  input  wire logic                   s_tuser,   // frame_start
  input  wire logic                   s_tlast,   // end_of_buffer
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status[2:0], record_kind[10:3], payload_bytes[42:11], stamp[74:43],
  // frame_checksum[106:75], zero pad above
  output logic [OUT_BYTES*8-1:0]      m_tdata
);

  logic     in_valid;
  in_word_t in_word;
  logic     advance;
  result_t  res;

  assign s_tready = !in_valid || advance;

  // input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // input register word
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word.data_byte     <= s_tdata;
      in_word.frame_start   <= s_tuser;
      in_word.end_of_buffer <= s_tlast;
    end
  end

  lfcv_frame_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .word_valid (in_valid),
    .word       (in_word),
    .advance    (advance),
    .res_valid  (m_tvalid),
    .res        (res),
    .res_ready  (m_tready)
  );

  // pack the result word, status in the low bits
  assign m_tdata = {{OUT_PAD{1'b0}}, res};

endmodule

`default_nettype wire

>>> sv/lfcv_checker.sv
// port-level checker for the log frame validator, bound to the top level
`default_nettype none
`include "log_frame_crc32c_validator_unit_macros.svh"

module lfcv_checker
  import lfcv_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [111:0] m_tdata
);

  logic [2:0]  st;
  logic [7:0]  kind;
  logic [31:0] stamp;

  assign st    = m_tdata[2:0];
  assign kind  = m_tdata[10:3];
  assign stamp = m_tdata[74:43];

  // a stalled result word holds
  `LFCV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // an ok frame has a known kind and a nonzero timestamp
  `LFCV_ASSERT_NOW(a_ok_fields, m_tvalid && st == ST_OK, kind <= KIND_MAX && stamp != 32'd0)

  // an unknown-kind status carries a kind above the limit
  `LFCV_ASSERT_NOW(a_kind_status, m_tvalid && st == ST_KIND, kind > KIND_MAX)

  // a fresh result follows an accepted byte via input and result registers
  `LFCV_ASSERT_NOW(a_result_cause, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind log_frame_crc32c_validator_unit lfcv_checker u_lfcv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench of the log frame crc32c validator, with its own frame tracker
`default_nettype none

module tb;
  import lfcv_pkg::*;

  localparam logic [31:0] CASTAGNOLI  = 32'h82F6_3B78;
  localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;
  localparam int          STALL_LIMIT = 1000;
  localparam int          HOLD_CYCLES = 200;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [1:0]             cfg_index = 2'd0;
  logic [31:0]            cfg_data  = 32'd0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = 8'd0;  // data_byte
  logic                   s_tuser   = 1'b0;  // frame_start
  logic                   s_tlast   = 1'b0;  // end_of_buffer
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // status, record_kind, payload_bytes, stamp, frame_checksum, zero pad
  logic [OUT_BYTES*8-1:0] m_tdata;

  // frame tracker state and its copy of the registers
  phase_t      trk_phase;
  logic [4:0]  trk_pos;
  logic [31:0] trk_left;
  logic [31:0] trk_crc;
  logic [7:0]  trk_kind;
  logic [31:0] trk_len;
  logic [31:0] trk_stamp;
  logic [31:0] trk_hcrc;
  logic [31:0] trk_fcrc;
  logic [31:0] trk_lim_stamp;
  logic [31:0] trk_lim_len;
  logic [1:0]  trk_compact;

  result_t due_status[$];

  int words_sent    = 0;
  int frames_sent   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int status_hits[6] = '{default: 0};
  int stall_idle    = 0;
  int hold_request  = 0;
  int hold_count    = 0;
  int stall_count   = 0;
  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;

  log_frame_crc32c_validator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // reflected crc32c, one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    int i;
    r = c ^ {24'd0, b};
    for (i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ CASTAGNOLI) : (r >> 1);
    return r;
  endfunction

  task automatic clear_frame_track();
    trk_pos   = 5'd0;
    trk_left  = 32'd0;
    trk_crc   = CRC_SEED;
    trk_kind  = 8'd0;
    trk_len   = 32'd0;
    trk_stamp = 32'd0;
    trk_hcrc  = 32'd0;
    trk_fcrc  = 32'd0;
  endtask

  function automatic status_t frame_crc_status();
    return (trk_fcrc == ~trk_crc) ? ST_OK : ST_FRAME_CRC;
  endfunction

  // advance the tracker by one accepted word, queue the status it causes
  task automatic follow_frame_byte(input logic [7:0] b, input logic start, input logic last);
    logic [4:0] pos;
    logic       done;
    status_t    st;
    result_t    r;
    done = 1'b0;
    st   = ST_OK;
    if (start) begin
      clear_frame_track();
      trk_phase = PH_HEADER;
    end
    if (trk_phase == PH_HEADER) begin
      pos = trk_pos;
      if (pos < HDR_CRC_SPAN)
        trk_crc = crc32c_byte(trk_crc, b);
      if (pos == 5'd0)
        trk_kind = b;
      else if (pos <= HDR_LEN_LAST)
        trk_len[8*(pos-1) +: 8] = b;
      else if (pos <= HDR_TS_LAST)
        trk_stamp[8*(pos-5) +: 8] = b;
      else if (pos <= HDR_HC_LAST)
        trk_hcrc[8*(pos-9) +: 8] = b;
      else
        trk_fcrc[8*(pos-13) +: 8] = b;
      if (pos < HDR_LAST) begin
        trk_pos = pos + 5'd1;
        if (last) begin
          done = 1'b1;
          st   = ST_TRUNC;
        end
      end else if (trk_hcrc != ~trk_crc) begin
        done = 1'b1;
        st   = ST_HDR_CRC;
      end else if (trk_kind > KIND_MAX) begin
        done = 1'b1;
        st   = ST_KIND;
      end else if (trk_stamp == 32'd0 || trk_stamp >= trk_lim_stamp ||
                   trk_len > trk_lim_len ||
                   ((trk_kind == {6'd0, trk_compact}) != (trk_len == 32'd0))) begin
        done = 1'b1;
        st   = ST_FIELDS;
      end else if (trk_len == 32'd0) begin
        done = 1'b1;
        st   = frame_crc_status();
      end else begin
        trk_left  = trk_len;
        trk_phase = PH_PAYLOAD;
        if (last) begin
          done = 1'b1;
          st   = ST_TRUNC;
        end
      end
    end else if (trk_phase == PH_PAYLOAD) begin
      trk_crc  = crc32c_byte(trk_crc, b);
      trk_left = trk_left - 32'd1;
      if (trk_left == 32'd0) begin
        done = 1'b1;
        st   = frame_crc_status();
      end else if (last) begin
        done = 1'b1;
        st   = ST_TRUNC;
      end
    end
    if (done) begin
      r.status         = st;
      r.record_kind    = trk_kind;
      r.payload_bytes  = trk_len;
      r.stamp          = trk_stamp;
      r.frame_checksum = trk_fcrc;
      due_status.push_back(r);
      trk_phase = (st == ST_OK) ? PH_IDLE : PH_SKIP;
    end
  endtask

  // offer one word, sometimes after a random gap, and wait until it is taken
  task automatic send_word(input logic [7:0] b, input logic start, input logic last);
    if (!tx_quiet && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    follow_frame_byte(b, start, last);
  endtask

  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_word(8'($urandom()), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // build a frame with matching crcs unless told otherwise; cut >= 0 stops after that byte
  task automatic send_frame(input logic [7:0] kind, input logic [31:0] len,
                            input logic [31:0] stamp, input int cut, input bit cut_last,
                            input bit bad_hcrc, input bit bad_fcrc);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  pay[$];
    logic [31:0] c;
    logic [31:0] hcrc;
    logic [31:0] fcrc;
    logic        last;
    int          pay_n;
    int          n;
    int          i;
    frame_bytes.push_back(kind);
    for (i = 0; i < 4; i++)
      frame_bytes.push_back(len[8*i +: 8]);
    for (i = 0; i < 4; i++)
      frame_bytes.push_back(stamp[8*i +: 8]);
    c = CRC_SEED;
    for (i = 0; i < 9; i++)
      c = crc32c_byte(c, frame_bytes[i]);
    hcrc = ~c;
    if (bad_hcrc)
      hcrc = hcrc ^ (32'd1 << $urandom_range(0, 31));
    // huge lengths only get a short tail of payload
    pay_n = (len <= 32'd512) ? int'(len) : 3;
    for (i = 0; i < pay_n; i++) begin
      pay.push_back(8'($urandom()));
      c = crc32c_byte(c, pay[i]);
    end
    fcrc = ~c;
    if (bad_fcrc)
      fcrc = fcrc ^ (32'd1 << $urandom_range(0, 31));
    for (i = 0; i < 4; i++)
      frame_bytes.push_back(hcrc[8*i +: 8]);
    for (i = 0; i < 4; i++)
      frame_bytes.push_back(fcrc[8*i +: 8]);
    for (i = 0; i < pay_n; i++)
      frame_bytes.push_back(pay[i]);
    n = (cut >= 0 && cut < frame_bytes.size()) ? cut + 1 : frame_bytes.size();
    for (i = 0; i < n; i++) begin
      last = 1'b0;
      if (i == n - 1)
        last = (cut >= 0) ? cut_last : 1'($urandom_range(0, 1));
      send_word(frame_bytes[i], i == 0, last);
    end
    frames_sent++;
  endtask

  // let every awaited status arrive, then the pipeline empty
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] ts, input logic [31:0] mx, input logic [1:0] cc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TS_LIMIT;
    cfg_data  <= ts;
    @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data  <= mx;
    @(posedge clk);
    // upper bits of the compact code write carry junk
    cfg_index <= CFG_COMPACT;
    cfg_data  <= {30'($urandom()), cc};
    @(posedge clk);
    cfg_we        <= 1'b0;
    trk_lim_stamp = ts;
    trk_lim_len   = mx;
    trk_compact   = cc;
  endtask

  // mostly well-formed frames fitted to the current registers, some broken
  task automatic random_frame();
    logic [7:0]  kind;
    logic [31:0] len;
    logic [31:0] stamp;
    logic [31:0] cap;
    int          pick;
    int          cut;
    pick = $urandom_range(0, 19);
    kind = (pick < 18) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(3, 255));
    cap  = (trk_lim_len < 32'd40) ? trk_lim_len : 32'd40;
    if (kind == {6'd0, trk_compact} || cap == 32'd0)
      len = 32'd0;
    else
      len = $urandom_range(1, cap);
    pick = $urandom_range(0, 11);
    if (pick == 0)
      len = (trk_lim_len != 32'hFFFF_FFFF) ? trk_lim_len + 32'd1 : $urandom();
    else if (pick == 1)
      len = (len == 32'd0) ? 32'($urandom_range(1, 8)) : 32'd0;
    stamp = (trk_lim_stamp > 32'd1) ? $urandom_range(1, trk_lim_stamp - 32'd1) : $urandom();
    pick = $urandom_range(0, 11);
    if (pick == 0)
      stamp = 32'd0;
    else if (pick == 1)
      stamp = trk_lim_stamp;
    else if (pick == 2)
      stamp = $urandom();
    cut  = $urandom_range(0, 17 + ((len < 32'd40) ? int'(len) : 40));
    pick = $urandom_range(0, 99);
    if (pick < 5)
      send_frame(kind, len, stamp, -1, 1'b0, 1'b1, 1'b0);
    else if (pick < 12)
      send_frame(kind, len, stamp, -1, 1'b0, 1'b0, 1'b1);
    else if (pick < 20)
      send_frame(kind, len, stamp, cut, 1'b1, 1'b0, 1'b0);
    else if (pick < 24)
      send_frame(kind, len, stamp, cut, 1'b0, 1'b0, 1'b0);
    else
      send_frame(kind, len, stamp, -1, 1'b0, 1'b0, 1'b0);
    if ($urandom_range(0, 15) == 0)
      send_noise($urandom_range(1, 4));
  endtask

  // at least one frame per status code, early ends, restarts and stray words
  task automatic test_directed_status();
    send_noise(2);
    send_frame(8'd0, 32'd1, 32'd1, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd2, 32'd0, 32'hFFFF_FFFE, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd2, 32'd0, 32'd5, -1, 1'b0, 1'b0, 1'b1);
    send_frame(8'd1, 32'd3, 32'd7, -1, 1'b0, 1'b1, 1'b0);
    send_noise(3);
    send_frame(8'hFF, 32'd2, 32'd9, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd3, 32'd2, 32'd9, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd0, 32'd4, 32'd0, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd0, 32'd4, 32'hFFFF_FFFF, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd0, 32'd0, 32'd10, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd2, 32'd5, 32'd10, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd1, MAX_PAYLOAD_RST + 32'd1, 32'd10, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd1, MAX_PAYLOAD_RST, 32'd10, 19, 1'b1, 1'b0, 1'b0);
    send_frame(8'd0, 32'd6, 32'd11, -1, 1'b0, 1'b0, 1'b1);
    send_frame(8'd0, 32'd6, 32'd12, 0, 1'b1, 1'b0, 1'b0);
    send_frame(8'd0, 32'd6, 32'd12, 16, 1'b1, 1'b0, 1'b0);
    // abandon mid header, the next frame start takes over
    send_frame(8'd0, 32'd6, 32'd12, 9, 1'b0, 1'b0, 1'b0);
    send_frame(8'd1, 32'd2, 32'd13, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd0, 32'd20, 32'd14, -1, 1'b1, 1'b0, 1'b0);
    settle_block();
  endtask

  // register extremes: zero and one timestamp limit, zero and full length, code three
  task automatic test_register_extremes();
    set_config(32'd0, 32'd0, 2'd0);
    send_frame(8'd0, 32'd0, 32'd1, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd1, 32'd3, 32'hFFFF_FFFF, -1, 1'b0, 1'b0, 1'b0);
    settle_block();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_frame(8'd2, 32'd0, 32'd3, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd2, 32'd4, 32'd3, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd0, 32'hFFFF_FFFF, 32'd3, -1, 1'b1, 1'b0, 1'b0);
    settle_block();
    set_config(32'd1, 32'd8, 2'd1);
    send_frame(8'd1, 32'd0, 32'd1, -1, 1'b0, 1'b0, 1'b0);
    settle_block();
    set_config(32'd2, 32'd0, 2'd0);
    send_frame(8'd0, 32'd0, 32'd1, -1, 1'b0, 1'b0, 1'b0);
    send_frame(8'd1, 32'd1, 32'd1, -1, 1'b0, 1'b0, 1'b0);
    settle_block();
  endtask

  // random frames under several register settings
  task automatic test_random_frames();
    int phase_no;
    int target;
    for (phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: set_config(TS_LIMIT_RST, MAX_PAYLOAD_RST, COMPACT_RST);
        1: set_config(32'd1000, 32'd20, 2'd0);
        2: set_config($urandom(), 32'($urandom_range(0, 64)), 2'd1);
        3: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        default: set_config(32'd2, 32'd0, 2'd0);
      endcase
      target = words_sent + 160;
      while (words_sent < target)
        random_frame();
      settle_block();
    end
  endtask

  // long output hold while short frames keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    set_config(TS_LIMIT_RST, MAX_PAYLOAD_RST, COMPACT_RST);
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 5; i++)
      send_frame(8'd2, 32'd0, 32'($urandom_range(1, 1000)), -1, 1'b0, 1'b0, 1'b0);
    settle_block();
  endtask

  // last stretch at full rate on both sides
  task automatic test_quiet_tail();
    int target;
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    target = words_sent + 150;
    while (words_sent < target)
      random_frame();
  endtask

  // receiver: random stall bursts plus the requested long hold
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_count   = hold_request;
      hold_request = 0;
    end
    if (hold_count > 0) begin
      hold_count--;
      m_tready <= 1'b0;
    end else if (stall_count > 0) begin
      stall_count--;
      m_tready <= 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
      stall_count = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each status word with the oldest awaited one
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[OUT_BITS-1:0]);
      results_seen++;
      if (got.status <= ST_TRUNC)
        status_hits[int'(got.status)]++;
      if (due_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected status word: status %0d kind %0d len %0d stamp %0d fcrc %h",
                   got.status, got.record_kind, got.payload_bytes, got.stamp,
                   got.frame_checksum);
      end else begin
        want = due_status.pop_front();
        if (got.status !== want.status || got.record_kind !== want.record_kind ||
            got.payload_bytes !== want.payload_bytes || got.stamp !== want.stamp ||
            got.frame_checksum !== want.frame_checksum) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: status %0d kind %0d len %0d stamp %0d fcrc %h",
                     want.status, want.record_kind, want.payload_bytes, want.stamp,
                     want.frame_checksum);
            $display("         got: status %0d kind %0d len %0d stamp %0d fcrc %h",
                     got.status, got.record_kind, got.payload_bytes, got.stamp,
                     got.frame_checksum);
          end
        end
      end
    end
  end

  // watchdog on cycles where no word moves on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_idle = 0;
    else
      stall_idle++;
    if (stall_idle >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    trk_phase     = PH_IDLE;
    trk_lim_stamp = TS_LIMIT_RST;
    trk_lim_len   = MAX_PAYLOAD_RST;
    trk_compact   = COMPACT_RST;
    clear_frame_track();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_status();
    test_register_extremes();
    test_random_frames();
    test_backpressure();
    test_quiet_tail();
    s_tvalid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("covered %0d input words in %0d frames, %0d status words checked, %0d mismatches",
             words_sent, frames_sent, results_seen, mismatches);
    $display("outcomes ok/hdr-crc/kind/fields/frame-crc/truncated: %0d/%0d/%0d/%0d/%0d/%0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/lfcv_pkg.sv
sv/lfcv_crc_byte.sv
sv/lfcv_frame_ctrl.sv
sv/log_frame_crc32c_validator_unit.sv
sv/lfcv_checker.sv
tb/sv/tb.sv
